FILE: rtl/sdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_pkg: shared types and constants of the dirty rectangle tracker
// Texture geometry, shadow address widths, the configuration bundle and the
// word that the front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package sdr_pkg;

  // Texture geometry and pixel size
  localparam int MAX_TEX_WIDTH  = 256;
  localparam int MAX_TEX_HEIGHT = 256;
  localparam int PIXEL_BITS     = 32;

  // Shadow store addressing: row in the high bits, column in the low bits
  localparam int COL_ADDR_W = $clog2(MAX_TEX_WIDTH);
  localparam int ROW_ADDR_W = $clog2(MAX_TEX_HEIGHT);
  localparam int ADDR_W     = COL_ADDR_W + ROW_ADDR_W;

  // Reset value of the row gap register
  localparam logic [7:0] GAP_RESET = 8'd16;

  // Queue between front and back end
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [8:0] texture_width;
    logic [8:0] texture_height;
    logic [7:0] area_x;
    logic [7:0] area_y;
    logic [8:0] area_width;
    logic [8:0] area_height;
    logic [7:0] max_row_gap;
  } sdr_cfg_t;

  // One classified pixel, passed from front end to back end
  typedef struct packed {
    logic [8:0] col;      // column inside the area
    logic [8:0] row;      // row inside the area
    logic       changed;  // pixel differed from the shadow copy
    logic       row_end;  // last pixel of an area row
    logic       last;     // last pixel of the area
    logic       row_ok;   // row lies inside the clip and the clip has width
  } sdr_item_t;

endpackage
`default_nettype wire

FILE: rtl/sdr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_front: pixel intake, clipping and shadow compare
// Counts the raster position, clips it against the texture, reads the shadow
// copy, compares and writes back changed pixels, and pushes one classified
// word per pixel into the queue. Also runs the clearing pass after reset.
// ----------------------------------------------------------------------------
module sdr_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  sdr_pkg::sdr_cfg_t        cfg,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [31:0]              in_pixel,
  input  wire  [sdr_pkg::Q_CNT_W-1:0] q_free,
  output logic                     push,
  output sdr_pkg::sdr_item_t       push_item,
  output logic                     clearing
);
  import sdr_pkg::*;

  localparam logic [9:0] TEX_W_CAP = 10'(MAX_TEX_WIDTH);
  localparam logic [9:0] TEX_H_CAP = 10'(MAX_TEX_HEIGHT);

  // Clip one dimension: min(len, min(tex, cap) - start), zero if start is past it
  function automatic logic [8:0] clip_extent(input logic [8:0] tex, input logic [9:0] cap,
                                             input logic [7:0] start, input logic [8:0] len);
    logic [9:0] lim;
    logic [9:0] room;
    lim  = ({1'b0, tex} > cap) ? cap : {1'b0, tex};
    room = lim - {2'b00, start};
    if ({2'b00, start} >= lim)
      clip_extent = 9'd0;
    else if ({1'b0, len} < room)
      clip_extent = len;
    else
      clip_extent = room[8:0];
  endfunction

  // Shadow copy of the texture
  logic [PIXEL_BITS-1:0] shadow_mem [2**ADDR_W];
  logic [PIXEL_BITS-1:0] rd_data_r;

  // Clearing pass state
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Raster position
  logic [8:0] col_r, col_nxt;
  logic [8:0] row_r, row_nxt;

  // Stage 1 (compare and write back)
  logic                  s1_valid_r;
  sdr_item_t             s1_item_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic                  s1_in_clip_r;

  // Last cycle's write, for a read that raced it
  logic                  fwd_valid_r;
  logic [ADDR_W-1:0]     fwd_addr_r;
  logic [PIXEL_BITS-1:0] fwd_data_r;

  logic [8:0]  clip_w, clip_h;
  logic        accept, row_end, last, in_clip, row_ok;
  logic [8:0]  tex_row, tex_col;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIXEL_BITS-1:0] shadow_val;
  logic        changed, wr_en;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [PIXEL_BITS-1:0] mem_wd;

  // Room is needed for the word in stage 1 and the one taken now
  assign in_ready = !clearing_r && (s1_valid_r ? (q_free >= Q_CNT_W'(2))
                                               : (q_free >= Q_CNT_W'(1)));
  assign accept   = in_valid && in_ready;
  assign clearing = clearing_r;

  // Classification of the incoming pixel
  always_comb begin
    clip_w  = clip_extent(cfg.texture_width, TEX_W_CAP, cfg.area_x, cfg.area_width);
    clip_h  = clip_extent(cfg.texture_height, TEX_H_CAP, cfg.area_y, cfg.area_height);
    row_end = ({1'b0, col_r} + 10'd1) >= {1'b0, cfg.area_width};
    last    = row_end && (({1'b0, row_r} + 10'd1) >= {1'b0, cfg.area_height});
    in_clip = (row_r < clip_h) && (col_r < clip_w);
    row_ok  = (row_r < clip_h) && (clip_w != 9'd0);
    tex_row = {1'b0, cfg.area_y} + row_r;
    tex_col = {1'b0, cfg.area_x} + col_r;
    rd_addr = {tex_row[ROW_ADDR_W-1:0], tex_col[COL_ADDR_W-1:0]};
    if (row_end) begin
      col_nxt = 9'd0;
      row_nxt = last ? 9'd0 : row_r + 9'd1;
    end else begin
      col_nxt = col_r + 9'd1;
      row_nxt = row_r;
    end
  end

  // Compare against the shadow, taking last cycle's write when it hit this address
  always_comb begin
    shadow_val = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data_r;
    changed    = s1_in_clip_r && (shadow_val != s1_pix_r);
    wr_en      = s1_valid_r && changed;
    push       = s1_valid_r;
    push_item  = s1_item_r;
    push_item.changed = changed;
    mem_we     = clearing_r || wr_en;
    mem_wa     = clearing_r ? clr_addr_r : s1_addr_r;
    mem_wd     = clearing_r ? '0 : s1_pix_r;
  end

  // Shadow memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      shadow_mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_data_r <= shadow_mem[rd_addr];
    end
  end

  // Control state: clearing pass, position counters, stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      col_r       <= 9'd0;
      row_r       <= 9'd0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == {ADDR_W{1'b1}}) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_valid_r  <= accept;
      fwd_valid_r <= wr_en;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.col     <= col_r;
      s1_item_r.row     <= row_r;
      s1_item_r.changed <= 1'b0;
      s1_item_r.row_end <= row_end;
      s1_item_r.last    <= last;
      s1_item_r.row_ok  <= row_ok;
      s1_pix_r          <= in_pixel[PIXEL_BITS-1:0];
      s1_addr_r         <= rd_addr;
      s1_in_clip_r      <= in_clip;
    end
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= s1_pix_r;
  end

endmodule
`default_nettype wire

FILE: rtl/sdr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_queue: short queue between front and back end
// A small register queue of classified words; it reports its free slots so
// that the front end only takes a pixel when its word is sure to fit.
// ----------------------------------------------------------------------------
module sdr_queue (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push,
  input  sdr_pkg::sdr_item_t          push_item,
  input  wire                         pop,
  output logic                        q_valid,
  output sdr_pkg::sdr_item_t          q_item,
  output logic [sdr_pkg::Q_CNT_W-1:0] q_free
);
  import sdr_pkg::*;

  sdr_item_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign q_free  = Q_CNT_W'(Q_DEPTH) - count_r;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sdr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_back: row span tracking, run merging and result register
// Keeps the changed span of the current row, merges changed rows into a run,
// decides when the run is emitted and holds the result word for the sink.
// ----------------------------------------------------------------------------
module sdr_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sdr_pkg::sdr_cfg_t    cfg,
  input  wire                  q_valid,
  input  sdr_pkg::sdr_item_t   q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [7:0]           rect_x,
  output logic [7:0]           rect_y,
  output logic [8:0]           rect_width,
  output logic [8:0]           rect_height,
  output logic                 rect_valid,
  output logic                 upload_done
);
  import sdr_pkg::*;

  // Row and run state
  logic       row_changed_r, row_changed_nxt;
  logic [7:0] row_left_r, row_left_nxt;
  logic [8:0] row_right_r, row_right_nxt;
  logic       run_open_r, run_open_nxt;
  logic [7:0] run_top_r, run_top_nxt;
  logic [8:0] run_bottom_r, run_bottom_nxt;
  logic [7:0] run_left_r, run_left_nxt;
  logic [8:0] run_right_r, run_right_nxt;

  // Result register
  logic       out_valid_r;
  logic [7:0] rect_x_r, rect_x_nxt;
  logic [7:0] rect_y_r, rect_y_nxt;
  logic [8:0] rect_width_r, rect_width_nxt;
  logic [8:0] rect_height_r, rect_height_nxt;
  logic       rect_valid_r;
  logic       upload_done_r;

  logic        go, emit, result;
  logic [10:0] gap_diff;
  logic        gap_hit;

  assign go  = q_valid && (!out_valid_r || out_ready);
  assign pop = go;

  assign out_valid   = out_valid_r;
  assign rect_x      = rect_x_r;
  assign rect_y      = rect_y_r;
  assign rect_width  = rect_width_r;
  assign rect_height = rect_height_r;
  assign rect_valid  = rect_valid_r;
  assign upload_done = upload_done_r;

  // Gap since the run's bottom; a negative distance counts as a hit
  assign gap_diff = {2'b00, q_item.row} + 11'd1 - {2'b00, run_bottom_r};
  assign gap_hit  = gap_diff[10] || (gap_diff[9:0] >= {2'b00, cfg.max_row_gap});

  // Next row span, run bounds and emit decision for the word at the head
  always_comb begin
    row_changed_nxt = row_changed_r;
    row_left_nxt    = row_left_r;
    row_right_nxt   = row_right_r;
    run_open_nxt    = run_open_r;
    run_top_nxt     = run_top_r;
    run_bottom_nxt  = run_bottom_r;
    run_left_nxt    = run_left_r;
    run_right_nxt   = run_right_r;
    emit            = 1'b0;

    // Widen the row span with a changed pixel
    if (q_item.changed) begin
      if (!row_changed_r) begin
        row_left_nxt = q_item.col[7:0];
      end
      row_right_nxt   = q_item.col + 9'd1;
      row_changed_nxt = 1'b1;
    end

    // Close the row: merge it into the run, or end the run once the gap is reached
    if (q_item.row_end) begin
      if (q_item.row_ok) begin
        if (row_changed_nxt) begin
          if (!run_open_r) begin
            run_open_nxt  = 1'b1;
            run_top_nxt   = q_item.row[7:0];
            run_left_nxt  = row_left_nxt;
            run_right_nxt = row_right_nxt;
          end else begin
            if (row_left_nxt < run_left_r) begin
              run_left_nxt = row_left_nxt;
            end
            if (row_right_nxt > run_right_r) begin
              run_right_nxt = row_right_nxt;
            end
          end
          run_bottom_nxt = q_item.row + 9'd1;
        end else if (run_open_r && gap_hit) begin
          emit = 1'b1;
        end
      end
      row_changed_nxt = 1'b0;
      row_left_nxt    = 8'd0;
      row_right_nxt   = 9'd0;
    end

    if (q_item.last && run_open_nxt) begin
      emit = 1'b1;
    end
    result = emit || q_item.last;

    // Result fields come from the run before it is closed
    if (emit) begin
      rect_x_nxt      = cfg.area_x + run_left_nxt;
      rect_y_nxt      = cfg.area_y + run_top_nxt;
      rect_width_nxt  = run_right_nxt - {1'b0, run_left_nxt};
      rect_height_nxt = run_bottom_nxt - {1'b0, run_top_nxt};
      run_open_nxt    = 1'b0;
    end else begin
      rect_x_nxt      = 8'd0;
      rect_y_nxt      = 8'd0;
      rect_width_nxt  = 9'd0;
      rect_height_nxt = 9'd0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_changed_r <= 1'b0;
      row_left_r    <= 8'd0;
      row_right_r   <= 9'd0;
      run_open_r    <= 1'b0;
      run_top_r     <= 8'd0;
      run_bottom_r  <= 9'd0;
      run_left_r    <= 8'd0;
      run_right_r   <= 9'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (go) begin
        row_changed_r <= row_changed_nxt;
        row_left_r    <= row_left_nxt;
        row_right_r   <= row_right_nxt;
        run_open_r    <= run_open_nxt;
        run_top_r     <= run_top_nxt;
        run_bottom_r  <= run_bottom_nxt;
        run_left_r    <= run_left_nxt;
        run_right_r   <= run_right_nxt;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= go && result;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (go && result) begin
      rect_x_r      <= rect_x_nxt;
      rect_y_r      <= rect_y_nxt;
      rect_width_r  <= rect_width_nxt;
      rect_height_r <= rect_height_nxt;
      rect_valid_r  <= emit;
      upload_done_r <= q_item.last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/shadow_compare_dirty_rect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shadow_compare_dirty_rect: dirty rectangle tracker against a shadow texture
// Compares an incoming pixel area with a shadow copy and reports the changed
// runs of rows as update rectangles.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock cycle in steady state, while the
// queue has room; the rate is set by the single read port and single write
// port of the shadow memory: the read port is used once per pixel and the
// write port at most once. A pixel's result, if any, passes position and
// memory read, then compare, write back and queue write, then run logic into
// the output register. After reset the shadow memory is cleared in a pass
// over all 65536 entries, one entry per cycle, during which no pixel is taken;
// configuration writes are taken at any time. The user writes configuration
// only while no pixel is in flight; the block itself does not enforce this.
module shadow_compare_dirty_rect (
  input  wire         clk,
  input  wire         rst_n,
  // Configuration
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [8:0]  cfg_data,
  // Pixel stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,     // [31:0] pixel_value
  // Rectangle stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,    // [7:0] rect_x, [15:8] rect_y,
                                    // [24:16] rect_width, [33:25] rect_height
  output logic        out_tuser,    // [0] rect_valid
  output logic        out_tlast     // upload_done
);
  import sdr_pkg::*;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_TEXTURE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_TEXTURE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_AREA_X         = 3'd2;
  localparam logic [2:0] CFG_AREA_Y         = 3'd3;
  localparam logic [2:0] CFG_AREA_WIDTH     = 3'd4;
  localparam logic [2:0] CFG_AREA_HEIGHT    = 3'd5;
  localparam logic [2:0] CFG_MAX_ROW_GAP    = 3'd6;

  sdr_cfg_t           cfg_r;
  logic               q_push, q_pop, q_valid, clearing;
  sdr_item_t          push_item, q_item;
  logic [Q_CNT_W-1:0] q_free;
  logic [7:0]         rect_x, rect_y;
  logic [8:0]         rect_width, rect_height;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.texture_width  <= 9'd0;
      cfg_r.texture_height <= 9'd0;
      cfg_r.area_x         <= 8'd0;
      cfg_r.area_y         <= 8'd0;
      cfg_r.area_width     <= 9'd0;
      cfg_r.area_height    <= 9'd0;
      cfg_r.max_row_gap    <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXTURE_WIDTH:  cfg_r.texture_width  <= cfg_data;
        CFG_TEXTURE_HEIGHT: cfg_r.texture_height <= cfg_data;
        CFG_AREA_X:         cfg_r.area_x         <= cfg_data[7:0];
        CFG_AREA_Y:         cfg_r.area_y         <= cfg_data[7:0];
        CFG_AREA_WIDTH:     cfg_r.area_width     <= cfg_data;
        CFG_AREA_HEIGHT:    cfg_r.area_height    <= cfg_data;
        CFG_MAX_ROW_GAP:    cfg_r.max_row_gap    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front end: position, clip, shadow compare
  sdr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata),
    .q_free    (q_free),
    .push      (q_push),
    .push_item (push_item),
    .clearing  (clearing)
  );

  // Queue between the two halves
  sdr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_free    (q_free)
  );

  // Back end: row spans, runs, result register
  sdr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .rect_valid  (out_tuser),
    .upload_done (out_tlast)
  );

  assign out_tdata = {6'd0, rect_height, rect_width, rect_y, rect_x};

`ifndef SYNTHESIS
  // A word is never pushed into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_free != '0) || q_pop)
    else $error("queue overflow");

  // No pixel is taken while the shadow is being cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("pixel taken during clearing pass");

  // A result without a rectangle carries zero bounds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata == 40'd0))
    else $error("empty result with nonzero bounds");

  // Every result carries a rectangle or marks the area's end
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser || out_tlast)
    else $error("result with neither rectangle nor done");
`endif

endmodule
`default_nettype wire
